// File: rtl/core/svm_pkg.sv
// Shared constants, opcodes and types of the stack machine execute unit.
package svm_pkg;

   // Storage sizes
   localparam int STACK_DEPTH = 256;
   localparam int NUM_VARS    = 256;
   localparam int SP_W        = $clog2(STACK_DEPTH);
   localparam int CNT_W       = SP_W + 1;
   localparam int VAR_AW      = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

   // Opcodes
   localparam logic [4:0] OP_NOP       = 5'd0;
   localparam logic [4:0] OP_LIT_INT   = 5'd1;
   localparam logic [4:0] OP_LIT_BOOL  = 5'd2;
   localparam logic [4:0] OP_ADD       = 5'd3;
   localparam logic [4:0] OP_SUB       = 5'd4;
   localparam logic [4:0] OP_MUL       = 5'd5;
   localparam logic [4:0] OP_DIV       = 5'd6;
   localparam logic [4:0] OP_MOD       = 5'd7;
   localparam logic [4:0] OP_AND       = 5'd8;
   localparam logic [4:0] OP_OR        = 5'd9;
   localparam logic [4:0] OP_XOR       = 5'd10;
   localparam logic [4:0] OP_NOT       = 5'd11;
   localparam logic [4:0] OP_EQ        = 5'd12;
   localparam logic [4:0] OP_NEQ       = 5'd13;
   localparam logic [4:0] OP_LT        = 5'd14;
   localparam logic [4:0] OP_LTE       = 5'd15;
   localparam logic [4:0] OP_GT        = 5'd16;
   localparam logic [4:0] OP_GTE       = 5'd17;
   localparam logic [4:0] OP_LOAD      = 5'd18;
   localparam logic [4:0] OP_SAVE      = 5'd19;
   localparam logic [4:0] OP_WR_INT    = 5'd20;
   localparam logic [4:0] OP_WR_BOOL   = 5'd21;
   localparam logic [4:0] OP_WR_STR    = 5'd22;
   localparam logic [4:0] OP_NEWLINE   = 5'd23;
   localparam logic [4:0] OP_READ      = 5'd24;
   localparam logic [4:0] OP_HALT      = 5'd25;

   // Result events
   localparam logic [2:0] EV_NONE  = 3'd0;
   localparam logic [2:0] EV_INT   = 3'd1;
   localparam logic [2:0] EV_BOOL  = 3'd2;
   localparam logic [2:0] EV_STR   = 3'd3;
   localparam logic [2:0] EV_NL    = 3'd4;
   localparam logic [2:0] EV_HALT  = 3'd5;
   localparam logic [2:0] EV_FAULT = 3'd6;

   // Fault codes
   localparam logic [1:0] FC_DIV0   = 2'd0;
   localparam logic [1:0] FC_OVER   = 2'd1;
   localparam logic [1:0] FC_UNDER  = 2'd2;
   localparam logic [1:0] FC_BADVAR = 2'd3;

   // Instruction class assigned by the front end
   typedef enum logic [3:0] {
      CL_NOP, CL_PUSH, CL_BIN, CL_DIVMOD, CL_NOT, CL_LOAD, CL_STORE,
      CL_WRITE, CL_STR, CL_NL, CL_HALT
   } class_type;

   // Decoded request passed from front to back
   typedef struct packed {
      logic [4:0]  kind;
      class_type   cls;
      logic [31:0] arg;
      logic [31:0] operand;   // value pushed by push or read
      logic        start;
      logic        var_ok;
   } item_type;

endpackage

// File: rtl/core/svm_if.sv
// Channel interfaces: request, response and configuration write.
interface svm_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  kind;
   logic [31:0] arg;
   logic [31:0] read_value;
   logic        start_of_program;
   modport source (output valid, kind, arg, read_value, start_of_program, input ready);
   modport sink (input valid, kind, arg, read_value, start_of_program, output ready);
endinterface

interface svm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [31:0] value;
   logic        string_valid;
   logic [1:0]  fault_code;
   modport source (output valid, event_res, value, string_valid, fault_code, input ready);
   modport sink (input valid, event_res, value, string_valid, fault_code, output ready);
endinterface

interface svm_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] string_count;
   modport source (output valid, string_count, input ready);
   modport sink (input valid, string_count, output ready);
endinterface

// File: rtl/core/svm_ram.sv
// Generic single write port, single read port RAM with registered read.
module svm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/core/svm_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module svm_front (
   input  logic              clock,
   input  logic              reset,
   svm_req_if.sink           req_if,
   output svm_pkg::item_type q_item,
   output logic              q_valid,
   input  logic              q_ready
);
   svm_pkg::item_type dec;
   svm_pkg::item_type q_ff [2];
   logic              wptr_ff, wptr_in;
   logic              rptr_ff, rptr_in;
   logic [1:0]        fill_ff, fill_in;
   logic              push, pop;

   // Classify the incoming request
   always_comb begin
      dec.kind    = req_if.kind;
      dec.arg     = req_if.arg;
      dec.start   = req_if.start_of_program;
      dec.operand = (req_if.kind == svm_pkg::OP_READ) ? req_if.read_value : req_if.arg;
      dec.var_ok  = !req_if.arg[31] &&
                    (req_if.arg[30:0] < 31'(svm_pkg::NUM_VARS));
      case (req_if.kind)
         svm_pkg::OP_LIT_INT, svm_pkg::OP_LIT_BOOL, svm_pkg::OP_READ:
            dec.cls = svm_pkg::CL_PUSH;
         svm_pkg::OP_ADD, svm_pkg::OP_SUB, svm_pkg::OP_MUL, svm_pkg::OP_AND,
         svm_pkg::OP_OR, svm_pkg::OP_XOR, svm_pkg::OP_EQ, svm_pkg::OP_NEQ,
         svm_pkg::OP_LT, svm_pkg::OP_LTE, svm_pkg::OP_GT, svm_pkg::OP_GTE:
            dec.cls = svm_pkg::CL_BIN;
         svm_pkg::OP_DIV, svm_pkg::OP_MOD:    dec.cls = svm_pkg::CL_DIVMOD;
         svm_pkg::OP_NOT:                     dec.cls = svm_pkg::CL_NOT;
         svm_pkg::OP_LOAD:                    dec.cls = svm_pkg::CL_LOAD;
         svm_pkg::OP_SAVE:                    dec.cls = svm_pkg::CL_STORE;
         svm_pkg::OP_WR_INT, svm_pkg::OP_WR_BOOL: dec.cls = svm_pkg::CL_WRITE;
         svm_pkg::OP_WR_STR:                  dec.cls = svm_pkg::CL_STR;
         svm_pkg::OP_NEWLINE:                 dec.cls = svm_pkg::CL_NL;
         svm_pkg::OP_HALT:                    dec.cls = svm_pkg::CL_HALT;
         default:                             dec.cls = svm_pkg::CL_NOP;
      endcase
   end

   // Two-entry queue
   assign req_if.ready = (fill_ff != 2'd2);
   assign push    = req_if.valid && req_if.ready;
   assign q_valid = (fill_ff != 2'd0);
   assign pop     = q_valid && q_ready;
   assign q_item  = q_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? !wptr_ff : wptr_ff;
      rptr_in = pop ? !rptr_ff : rptr_ff;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         q_ff[wptr_ff] <= dec;
      end
   end
endmodule

// File: rtl/core/svm_back.sv
// Back end: executes queued requests against the stack and variable memories.
module svm_back (
   input  logic              clock,
   input  logic              reset,
   input  svm_pkg::item_type q_item,
   input  logic              q_valid,
   output logic              q_ready,
   input  logic [15:0]       string_count,
   svm_rsp_if.source         rsp_if
);
   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_DFIN} state_type;

   state_type                 state_ff, state_in;
   svm_pkg::item_type         it_ff, it_in;
   logic [svm_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      stopped_ff, stopped_in;
   logic [31:0]               top_ff, top_in;
   logic [31:0]               dq_ff, dq_in, dr_ff, dr_in, dvs_ff, dvs_in;
   logic [4:0]                dstep_ff, dstep_in;
   logic                      negq_ff, negq_in, negr_ff, negr_in;
   logic                      rvalid_ff, rvalid_in;
   logic [2:0]                rev_ff, rev_in;
   logic [31:0]               rval_ff, rval_in;
   logic                      rsv_ff, rsv_in;
   logic [1:0]                rfc_ff, rfc_in;
   logic [svm_pkg::NUM_VARS-1:0] vvld_ff, vvld_in;
   logic                      vrv_ff, vrv_in;

   // Memory ports
   logic                       stk_we, stk_re;
   logic [svm_pkg::SP_W-1:0]   stk_waddr, stk_raddr;
   logic [31:0]                stk_wdata, stk_rd;
   logic                       var_we, var_re;
   logic [svm_pkg::VAR_AW-1:0] var_addr;
   logic [31:0]                var_rd;

   // Working values
   logic                      ofree, emit;
   logic [2:0]                ev;
   logic [31:0]               val;
   logic                      sv;
   logic [1:0]                fc;
   logic [svm_pkg::CNT_W-1:0] eff_cnt;
   logic [31:0]               a, b, r, vrd, mag_a, mag_b;
   logic [31:0]               q_fix, r_fix;
   logic [32:0]               rem_sh;
   logic                      rem_ge;

   // Entries below the top of stack live in the RAM; the top is held in top_ff
   svm_ram #(.WIDTH(32), .DEPTH(svm_pkg::STACK_DEPTH)) u_stack (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .re(stk_re), .raddr(stk_raddr), .rdata(stk_rd)
   );

   svm_ram #(.WIDTH(32), .DEPTH(svm_pkg::NUM_VARS)) u_vars (
      .clock(clock), .we(var_we), .waddr(var_addr), .wdata(top_ff),
      .re(var_re), .raddr(var_addr), .rdata(var_rd)
   );

   assign ofree = !rvalid_ff || rsp_if.ready;
   assign a     = stk_rd;
   assign b     = top_ff;
   assign vrd   = vrv_ff ? var_rd : 32'd0;
   assign mag_a = a[31] ? (32'd0 - a) : a;
   assign mag_b = b[31] ? (32'd0 - b) : b;

   // One restoring divider step
   assign rem_sh = {dr_ff, dq_ff[31]};
   assign rem_ge = (rem_sh >= {1'b0, dvs_ff});
   assign q_fix  = negq_ff ? (32'd0 - dq_ff) : dq_ff;
   assign r_fix  = negr_ff ? (32'd0 - dr_ff) : dr_ff;

   // Binary operation result
   always_comb begin
      case (it_ff.kind)
         svm_pkg::OP_ADD: r = a + b;
         svm_pkg::OP_SUB: r = a - b;
         svm_pkg::OP_MUL: r = a * b;
         svm_pkg::OP_AND: r = {31'd0, (a != 32'd0) && (b != 32'd0)};
         svm_pkg::OP_OR:  r = {31'd0, (a != 32'd0) || (b != 32'd0)};
         svm_pkg::OP_XOR: r = {31'd0, (a != 32'd0) != (b != 32'd0)};
         svm_pkg::OP_EQ:  r = {31'd0, a == b};
         svm_pkg::OP_NEQ: r = {31'd0, a != b};
         svm_pkg::OP_LT:  r = {31'd0, $signed(a) < $signed(b)};
         svm_pkg::OP_LTE: r = {31'd0, $signed(a) <= $signed(b)};
         svm_pkg::OP_GT:  r = {31'd0, $signed(a) > $signed(b)};
         default:         r = {31'd0, $signed(a) >= $signed(b)};
      endcase
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      it_in      = it_ff;
      cnt_in     = cnt_ff;
      stopped_in = stopped_ff;
      top_in     = top_ff;
      dq_in      = dq_ff;
      dr_in      = dr_ff;
      dvs_in     = dvs_ff;
      dstep_in   = dstep_ff;
      negq_in    = negq_ff;
      negr_in    = negr_ff;
      vvld_in    = vvld_ff;
      vrv_in     = vrv_ff;
      q_ready    = 1'b0;
      stk_we     = 1'b0;
      stk_waddr  = svm_pkg::SP_W'(cnt_ff - 1'b1);
      stk_wdata  = top_ff;
      stk_re     = 1'b0;
      var_we     = 1'b0;
      var_re     = 1'b0;
      var_addr   = it_ff.arg[svm_pkg::VAR_AW-1:0];
      eff_cnt    = q_item.start ? '0 : cnt_ff;
      stk_raddr  = svm_pkg::SP_W'(eff_cnt - 2'd2);
      emit       = 1'b0;
      ev         = svm_pkg::EV_NONE;
      val        = 32'd0;
      sv         = 1'b0;
      fc         = svm_pkg::FC_DIV0;

      case (state_ff)
         S_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               it_in    = q_item;
               cnt_in   = eff_cnt;
               if (q_item.start) begin
                  stopped_in = 1'b0;
               end
               stk_re   = 1'b1;
               var_re   = 1'b1;
               var_addr = q_item.arg[svm_pkg::VAR_AW-1:0];
               vrv_in   = vvld_ff[q_item.arg[svm_pkg::VAR_AW-1:0]];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (ofree) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (!stopped_ff) begin
                  case (it_ff.cls)
                     svm_pkg::CL_PUSH: begin
                        if (cnt_ff == svm_pkg::CNT_W'(svm_pkg::STACK_DEPTH)) begin
                           ev = svm_pkg::EV_FAULT;
                           fc = svm_pkg::FC_OVER;
                        end else begin
                           stk_we = (cnt_ff != '0);
                           top_in = it_ff.operand;
                           cnt_in = cnt_ff + 1'b1;
                        end
                     end
                     svm_pkg::CL_BIN: begin
                        if (cnt_ff < svm_pkg::CNT_W'(2)) begin
                           ev = svm_pkg::EV_FAULT;
                           fc = svm_pkg::FC_UNDER;
                        end else begin
                           top_in = r;
                           cnt_in = cnt_ff - 1'b1;
                        end
                     end
                     svm_pkg::CL_DIVMOD: begin
                        if (cnt_ff < svm_pkg::CNT_W'(2)) begin
                           ev = svm_pkg::EV_FAULT;
                           fc = svm_pkg::FC_UNDER;
                        end else if (b == 32'd0) begin
                           ev = svm_pkg::EV_FAULT;
                           fc = svm_pkg::FC_DIV0;
                        end else begin
                           // result goes out after the divider finishes
                           emit     = 1'b0;
                           dq_in    = mag_a;
                           dr_in    = 32'd0;
                           dvs_in   = mag_b;
                           dstep_in = '0;
                           negq_in  = a[31] ^ b[31];
                           negr_in  = a[31];
                           state_in = S_DIV;
                        end
                     end
                     svm_pkg::CL_NOT: begin
                        if (cnt_ff == '0) begin
                           ev = svm_pkg::EV_FAULT;
                           fc = svm_pkg::FC_UNDER;
                        end else begin
                           top_in = {31'd0, top_ff == 32'd0};
                        end
                     end
                     svm_pkg::CL_LOAD: begin
                        if (!it_ff.var_ok) begin
                           ev = svm_pkg::EV_FAULT;
                           fc = svm_pkg::FC_BADVAR;
                        end else if (cnt_ff ==
                                     svm_pkg::CNT_W'(svm_pkg::STACK_DEPTH)) begin
                           ev = svm_pkg::EV_FAULT;
                           fc = svm_pkg::FC_OVER;
                        end else begin
                           stk_we = (cnt_ff != '0);
                           top_in = vrd;
                           cnt_in = cnt_ff + 1'b1;
                        end
                     end
                     svm_pkg::CL_STORE: begin
                        if (!it_ff.var_ok) begin
                           ev = svm_pkg::EV_FAULT;
                           fc = svm_pkg::FC_BADVAR;
                        end else if (cnt_ff == '0) begin
                           ev = svm_pkg::EV_FAULT;
                           fc = svm_pkg::FC_UNDER;
                        end else begin
                           var_we            = 1'b1;
                           vvld_in[var_addr] = 1'b1;
                           top_in            = stk_rd;
                           cnt_in            = cnt_ff - 1'b1;
                        end
                     end
                     svm_pkg::CL_WRITE: begin
                        if (cnt_ff == '0) begin
                           ev = svm_pkg::EV_FAULT;
                           fc = svm_pkg::FC_UNDER;
                        end else begin
                           if (it_ff.kind == svm_pkg::OP_WR_INT) begin
                              ev  = svm_pkg::EV_INT;
                              val = top_ff;
                           end else begin
                              ev  = svm_pkg::EV_BOOL;
                              val = {31'd0, top_ff != 32'd0};
                           end
                           top_in = stk_rd;
                           cnt_in = cnt_ff - 1'b1;
                        end
                     end
                     svm_pkg::CL_STR: begin
                        ev  = svm_pkg::EV_STR;
                        val = it_ff.arg;
                        sv  = !it_ff.arg[31] &&
                              (it_ff.arg[30:0] < {15'd0, string_count});
                     end
                     svm_pkg::CL_NL: ev = svm_pkg::EV_NL;
                     svm_pkg::CL_HALT: begin
                        ev         = svm_pkg::EV_HALT;
                        stopped_in = 1'b1;
                     end
                     default: ev = svm_pkg::EV_NONE;
                  endcase
                  if (ev == svm_pkg::EV_FAULT) begin
                     stopped_in = 1'b1;
                  end
               end
            end
         end
         S_DIV: begin
            dq_in    = {dq_ff[30:0], rem_ge};
            dr_in    = rem_ge ? 32'(rem_sh - {1'b0, dvs_ff}) : rem_sh[31:0];
            dstep_in = dstep_ff + 1'b1;
            if (dstep_ff == 5'd31) begin
               state_in = S_DFIN;
            end
         end
         S_DFIN: begin
            if (ofree) begin
               emit     = 1'b1;
               top_in   = (it_ff.kind == svm_pkg::OP_DIV) ? q_fix : r_fix;
               cnt_in   = cnt_ff - 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Response register
      rvalid_in = emit ? 1'b1 : (rsp_if.ready ? 1'b0 : rvalid_ff);
      rev_in    = emit ? ev  : rev_ff;
      rval_in   = emit ? val : rval_ff;
      rsv_in    = emit ? sv  : rsv_ff;
      rfc_in    = emit ? ((ev == svm_pkg::EV_FAULT) ? fc : svm_pkg::FC_DIV0) : rfc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         stopped_ff <= 1'b0;
         rvalid_ff  <= 1'b0;
         vvld_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         stopped_ff <= stopped_in;
         rvalid_ff  <= rvalid_in;
         vvld_ff    <= vvld_in;
      end
      it_ff    <= it_in;
      top_ff   <= top_in;
      dq_ff    <= dq_in;
      dr_ff    <= dr_in;
      dvs_ff   <= dvs_in;
      dstep_ff <= dstep_in;
      negq_ff  <= negq_in;
      negr_ff  <= negr_in;
      vrv_ff   <= vrv_in;
      rev_ff   <= rev_in;
      rval_ff  <= rval_in;
      rsv_ff   <= rsv_in;
      rfc_ff   <= rfc_in;
   end

   assign rsp_if.valid        = rvalid_ff;
   assign rsp_if.event_res    = rev_ff;
   assign rsp_if.value        = rval_ff;
   assign rsp_if.string_valid = rsv_ff;
   assign rsp_if.fault_code   = rfc_ff;
endmodule

// File: rtl/core/stack_vm_execute_unit_core.sv
// Stack machine execute unit: one response per request.
// A request waits in the front-end queue; the back end reads the stack RAM in S_IDLE
// and registers the response in S_EXEC; divide and modulo step a radix-2 divider once
// per cycle in S_DIV and respond from S_DFIN. The back end takes one request at a time,
// bound by the stack RAM read then write; divide and modulo hold it until S_DFIN.
// Reset clears the stack count, the halt flag, the variable valid flags (variables then read as zero) and string_count.
module stack_vm_execute_unit_core (
   input  logic       clock,
   input  logic       reset,
   svm_req_if.sink    req_if,
   svm_rsp_if.source  rsp_if,
   svm_csr_if.sink    csr_if
);
   svm_pkg::item_type q_item;
   logic              q_valid, q_ready;
   logic [15:0]       string_count_ff, string_count_in;

   // Configuration register
   assign csr_if.ready    = 1'b1;
   assign string_count_in = (csr_if.valid && csr_if.ready) ? csr_if.string_count
                                                           : string_count_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         string_count_ff <= 16'd0;
      end else begin
         string_count_ff <= string_count_in;
      end
   end

   svm_front u_front (
      .clock(clock), .reset(reset), .req_if(req_if),
      .q_item(q_item), .q_valid(q_valid), .q_ready(q_ready)
   );

   svm_back u_back (
      .clock(clock), .reset(reset), .q_item(q_item), .q_valid(q_valid),
      .q_ready(q_ready), .string_count(string_count_ff), .rsp_if(rsp_if)
   );
endmodule

// File: rtl/core/svm_checker.sv
// Port-level assertions for the execute unit, bound to the top level.
module svm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_event_res,
   input logic [31:0] rsp_value,
   input logic        rsp_string_valid,
   input logic [1:0]  rsp_fault_code
);
   // No response right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Stalled response holds its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_value))
      else $error("stalled response changed");

   // Fault code only carried by faults
   a_fc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res != svm_pkg::EV_FAULT) |-> rsp_fault_code == 2'd0)
      else $error("fault code on non-fault response");

   // String flag only on string output
   a_sv: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_string_valid) |-> rsp_event_res == svm_pkg::EV_STR)
      else $error("string flag on non-string response");

   // Faults, halts and newlines carry a zero value
   a_val: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_res == svm_pkg::EV_FAULT ||
                     rsp_event_res == svm_pkg::EV_HALT ||
                     rsp_event_res == svm_pkg::EV_NL)) |-> rsp_value == 32'd0)
      else $error("nonzero value on control response");
endmodule

bind stack_vm_execute_unit_core svm_checker u_svm_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready),
   .rsp_event_res(rsp_if.event_res), .rsp_value(rsp_if.value),
   .rsp_string_valid(rsp_if.string_valid), .rsp_fault_code(rsp_if.fault_code)
);

// File: tb/stack_vm_execute_unit_core_test.sv
// Self-checking stack machine execute unit testbench: directed, overflow, stall and random tests.
module stack_vm_execute_unit_core_test;
   import svm_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;

   svm_req_if req_if ();
   svm_rsp_if rsp_if ();
   svm_csr_if csr_if ();

   stack_vm_execute_unit_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   typedef struct packed {
      logic [2:0]  ev;
      logic [31:0] value;
      logic        sv;
      logic [1:0]  fc;
   } outcome_type;

   typedef struct {
      logic [4:0]  kind;
      logic [31:0] arg;
      logic [31:0] rd;
      logic        start;
      logic        typed;  // expected outcome given in the table
      outcome_type want;
   } row_type;

   // Shadow machine state
   logic [31:0] shadow_stack [STACK_DEPTH];
   int          shadow_count;
   logic [31:0] shadow_vars [NUM_VARS];
   logic        shadow_stopped;
   logic [15:0] shadow_strings;

   outcome_type outcome_q [$];
   int          sent, got;
   logic        hold_rsp;   // long receiver stall

   function automatic outcome_type mk(logic [2:0] ev, logic [31:0] v, logic sv,
                                      logic [1:0] fc);
      outcome_type o;
      o.ev = ev; o.value = v; o.sv = sv; o.fc = fc;
      return o;
   endfunction

   function automatic outcome_type fault_out(logic [1:0] fc);
      shadow_stopped = 1'b1;
      return mk(EV_FAULT, 32'd0, 1'b0, fc);
   endfunction

   // Compute the outcome of one instruction and update shadow state
   function automatic outcome_type execute_instr(logic [4:0] kind, logic [31:0] arg,
                                                 logic [31:0] rd, logic start);
      logic signed [31:0] a, b, sarg;
      logic [31:0] r, ua, ub, q, m;
      sarg = arg;
      if (start) begin
         shadow_count = 0;
         shadow_stopped = 1'b0;
      end
      if (shadow_stopped) return mk(EV_NONE, 32'd0, 1'b0, 2'd0);
      case (kind)
         OP_LIT_INT, OP_LIT_BOOL, OP_READ: begin
            if (shadow_count >= STACK_DEPTH) return fault_out(FC_OVER);
            shadow_stack[SP_W'(shadow_count)] = (kind == OP_READ) ? rd : arg;
            shadow_count++;
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR,
         OP_EQ, OP_NEQ, OP_LT, OP_LTE, OP_GT, OP_GTE: begin
            if (shadow_count < 2) return fault_out(FC_UNDER);
            b = shadow_stack[SP_W'(shadow_count - 1)];
            a = shadow_stack[SP_W'(shadow_count - 2)];
            case (kind)
               OP_ADD: r = a + b;
               OP_SUB: r = a - b;
               OP_MUL: r = a * b;
               OP_DIV, OP_MOD: begin
                  if (b == 0) return fault_out(FC_DIV0);
                  ua = a[31] ? -a : a;
                  ub = b[31] ? -b : b;
                  q = ua / ub;
                  m = ua % ub;
                  if (kind == OP_DIV) r = (a[31] ^ b[31]) ? -q : q;
                  else r = a[31] ? -m : m;
               end
               OP_AND: r = {31'd0, (a != 0) && (b != 0)};
               OP_OR:  r = {31'd0, (a != 0) || (b != 0)};
               OP_XOR: r = {31'd0, (a != 0) != (b != 0)};
               OP_EQ:  r = {31'd0, a == b};
               OP_NEQ: r = {31'd0, a != b};
               OP_LT:  r = {31'd0, a < b};
               OP_LTE: r = {31'd0, a <= b};
               OP_GT:  r = {31'd0, a > b};
               default: r = {31'd0, a >= b};
            endcase
            shadow_count--;
            shadow_stack[SP_W'(shadow_count - 1)] = r;
         end
         OP_NOT: begin
            if (shadow_count < 1) return fault_out(FC_UNDER);
            shadow_stack[SP_W'(shadow_count - 1)] =
               {31'd0, shadow_stack[SP_W'(shadow_count - 1)] == 32'd0};
         end
         OP_LOAD, OP_SAVE: begin
            if (sarg < 0 || sarg >= NUM_VARS) return fault_out(FC_BADVAR);
            if (kind == OP_LOAD) begin
               if (shadow_count >= STACK_DEPTH) return fault_out(FC_OVER);
               shadow_stack[SP_W'(shadow_count)] = shadow_vars[VAR_AW'(sarg)];
               shadow_count++;
            end else begin
               if (shadow_count < 1) return fault_out(FC_UNDER);
               shadow_count--;
               shadow_vars[VAR_AW'(sarg)] = shadow_stack[SP_W'(shadow_count)];
            end
         end
         OP_WR_INT, OP_WR_BOOL: begin
            if (shadow_count < 1) return fault_out(FC_UNDER);
            shadow_count--;
            a = shadow_stack[SP_W'(shadow_count)];
            if (kind == OP_WR_INT) return mk(EV_INT, a, 1'b0, 2'd0);
            return mk(EV_BOOL, {31'd0, a != 0}, 1'b0, 2'd0);
         end
         OP_WR_STR:
            return mk(EV_STR, arg,
                      (sarg >= 0) && (sarg < $signed({16'd0, shadow_strings})), 2'd0);
         OP_NEWLINE: return mk(EV_NL, 32'd0, 1'b0, 2'd0);
         OP_HALT: begin
            shadow_stopped = 1'b1;
            return mk(EV_HALT, 32'd0, 1'b0, 2'd0);
         end
         default: ;
      endcase
      return mk(EV_NONE, 32'd0, 1'b0, 2'd0);
   endfunction

   // Send one request, queueing its expected outcome at acceptance
   task automatic send_instr(logic [4:0] kind, logic [31:0] arg, logic [31:0] rd,
                             logic start, logic typed = 1'b0,
                             outcome_type want = '{3'd0, 32'd0, 1'b0, 2'd0});
      outcome_type o;
      int          gap;
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.kind <= kind;
      req_if.arg <= arg;
      req_if.read_value <= rd;
      req_if.start_of_program <= start;
      do @(posedge clock); while (!req_if.ready);
      o = execute_instr(kind, arg, rd, start);
      outcome_q.push_back(typed ? want : o);
      sent++;
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_strings(logic [15:0] n);
      csr_if.valid <= 1'b1;
      csr_if.string_count <= n;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      shadow_strings = n;
   endtask

   // Response side: random stalls, compare against oldest expectation
   initial begin
      int gap;
      outcome_type w;
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            got++;
            if (outcome_q.size() == 0) begin
               $error("response with nothing outstanding");
               errors++;
            end else begin
               w = outcome_q.pop_front();
               if (rsp_if.event_res !== w.ev) begin
                  $error("event_res expected %0d got %0d", w.ev, rsp_if.event_res); errors++;
               end
               if (rsp_if.value !== w.value) begin
                  $error("value expected %0h got %0h", w.value, rsp_if.value); errors++;
               end
               if (rsp_if.string_valid !== w.sv) begin
                  $error("string_valid expected %0d got %0d", w.sv, rsp_if.string_valid);
                  errors++;
               end
               if (rsp_if.fault_code !== w.fc) begin
                  $error("fault_code expected %0d got %0d", w.fc, rsp_if.fault_code); errors++;
               end
            end
            gap = $urandom_range(0, 3);
            if (gap != 0) rsp_if.ready <= 1'b0;
         end else if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
         end else if (!rsp_if.ready) begin
            if (gap > 0) gap--;
            if (gap == 0) rsp_if.ready <= 1'b1;
         end else begin
            gap = 0;
         end
      end
   end

   // Random operand with bias to edge values
   function automatic logic [31:0] rand_val();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 2) - 1;
         3: return $urandom_range(0, 20);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_var();
      if ($urandom_range(0, 15) == 0) return $urandom;
      return $urandom_range(0, NUM_VARS - 1);
   endfunction

   // Stimulus
   initial begin
      row_type    table_rows [$];
      row_type    r;
      int         n;
      logic [4:0] k;
      hold_rsp = 1'b0;
      req_if.valid = 1'b0; req_if.kind = '0; req_if.arg = '0;
      req_if.read_value = '0; req_if.start_of_program = 1'b0;
      csr_if.valid = 1'b0; csr_if.string_count = '0;
      shadow_count = 0; shadow_stopped = 0; shadow_strings = 0;
      foreach (shadow_vars[i]) shadow_vars[i] = 0;
      foreach (shadow_stack[i]) shadow_stack[i] = 0;
      sent = 0; got = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_strings(16'd3);

      // Directed table
      table_rows = '{
         '{OP_WR_INT,   0, 0, 1, 1, '{EV_FAULT, 0, 0, FC_UNDER}},
         '{OP_NEWLINE,  0, 0, 0, 1, '{EV_NONE, 0, 0, 0}},
         '{OP_LOAD,     5, 0, 1, 1, '{EV_NONE, 0, 0, 0}},
         '{OP_WR_INT,   0, 0, 0, 1, '{EV_INT, 0, 0, 0}},
         '{OP_LIT_INT,  32'h8000_0000, 0, 0, 1, '{EV_NONE, 0, 0, 0}},
         '{OP_LIT_INT,  32'hffff_ffff, 0, 0, 1, '{EV_NONE, 0, 0, 0}},
         '{OP_DIV,      0, 0, 0, 1, '{EV_NONE, 0, 0, 0}},
         '{OP_WR_INT,   0, 0, 0, 1, '{EV_INT, 32'h8000_0000, 0, 0}},
         '{OP_READ,     0, 32'h7fff_ffff, 0, 1, '{EV_NONE, 0, 0, 0}},
         '{OP_LIT_INT,  0, 0, 0, 1, '{EV_NONE, 0, 0, 0}},
         '{OP_MOD,      0, 0, 0, 1, '{EV_FAULT, 0, 0, FC_DIV0}},
         '{OP_LIT_INT,  -7, 0, 1, 0, '{EV_NONE, 0, 0, 0}},
         '{OP_LIT_INT,  2, 0, 0, 0, '{EV_NONE, 0, 0, 0}},
         '{OP_MOD,      0, 0, 0, 0, '{EV_NONE, 0, 0, 0}},
         '{OP_NOT,      0, 0, 0, 0, '{EV_NONE, 0, 0, 0}},
         '{OP_WR_BOOL,  0, 0, 0, 0, '{EV_NONE, 0, 0, 0}},
         '{OP_SAVE,     NUM_VARS, 0, 0, 1, '{EV_FAULT, 0, 0, FC_BADVAR}},
         '{OP_LOAD,     -1, 0, 1, 1, '{EV_FAULT, 0, 0, FC_BADVAR}},
         '{OP_WR_STR,   2, 0, 1, 1, '{EV_STR, 2, 1, 0}},
         '{OP_WR_STR,   3, 0, 0, 1, '{EV_STR, 3, 0, 0}},
         '{OP_WR_STR,   -1, 0, 0, 1, '{EV_STR, 32'hffff_ffff, 0, 0}},
         '{OP_NEWLINE,  0, 0, 0, 1, '{EV_NL, 0, 0, 0}},
         '{5'd31,       0, 0, 0, 1, '{EV_NONE, 0, 0, 0}},
         '{OP_HALT,     0, 0, 0, 1, '{EV_HALT, 0, 0, 0}}
      };
      foreach (table_rows[i]) begin
         r = table_rows[i];
         send_instr(r.kind, r.arg, r.rd, r.start, r.typed, r.want);
      end
      // Every binary op and compare after a fresh start
      for (int op = OP_ADD; op <= OP_GTE; op++) begin
         send_instr(OP_LIT_INT, rand_val(), 32'd0, 1'b1);
         send_instr(OP_LIT_INT, rand_val(), 32'd0, 1'b0);
         send_instr(op[4:0], 32'd0, 32'd0, 1'b0);
         send_instr(OP_WR_INT, 32'd0, 32'd0, 1'b0);
      end
      // Fill the stack, then overflow it with one more push
      send_instr(OP_NOP, 32'd0, 32'd0, 1'b1);
      for (int i = 0; i < STACK_DEPTH; i++) send_instr(OP_READ, 32'd0, $urandom, 1'b0);
      send_instr(OP_LIT_BOOL, 32'd1, 32'd0, 1'b0);
      wait_idle();

      // Long receiver stall while requests keep coming
      hold_rsp = 1'b1;
      fork
         begin repeat (300) @(posedge clock); hold_rsp = 1'b0; end
         for (int i = 0; i < 40; i++) send_instr(OP_LIT_INT, $urandom, 32'd0, i == 0);
      join

      // Random programs across several string_count settings
      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         case (phase)
            0: write_strings(16'd0);
            1: write_strings(16'hffff);
            2: write_strings(16'd1);
            default: write_strings(16'($urandom));
         endcase
         n = 0;
         while (n < 240) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise: any opcode including unknown ones
               k = 5'($urandom);
               send_instr(k, $urandom, $urandom, $urandom_range(0, 7) == 0);
               n++;
            end else begin
               // well-formed program, random content
               send_instr(OP_LIT_INT, rand_val(), 32'd0, 1'b1);
               n++;
               repeat ($urandom_range(4, 20)) begin
                  case ($urandom_range(0, 7))
                     0: send_instr(OP_LIT_INT, rand_val(), 32'd0, 1'b0);
                     1: send_instr(OP_READ, 32'd0, rand_val(), 1'b0);
                     2: send_instr(OP_LOAD, rand_var(), 32'd0, 1'b0);
                     3: send_instr(OP_SAVE, rand_var(), 32'd0, 1'b0);
                     4: begin
                        k = 5'($urandom_range(OP_ADD, OP_GTE));
                        send_instr(OP_LIT_INT, rand_val(), 32'd0, 1'b0);
                        send_instr(k, 32'd0, 32'd0, 1'b0);
                        n++;
                     end
                     5: send_instr(5'($urandom_range(OP_WR_INT, OP_NEWLINE)), rand_val(),
                                   32'd0, 1'b0);
                     6: send_instr(OP_NOT, 32'd0, 32'd0, 1'b0);
                     default: send_instr(OP_LIT_BOOL, $urandom_range(0, 1), 32'd0, 1'b0);
                  endcase
                  n++;
               end
               if ($urandom_range(0, 1) != 0) begin
                  send_instr(OP_HALT, 32'd0, 32'd0, 1'b0);
                  n++;
               end
            end
         end
      end
      wait_idle();
      $display("Ran %0d requests and checked %0d responses over directed, overflow,", sent, got);
      $display("stall and random program phases with four string_count settings.");
      if (errors == 0 && outcome_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
